// ----- src/slt_pkg.sv -----
// Shared types, constants and byte classification for the script lexer tokenizer.
package slt_pkg;

  localparam int unsigned SOURCE_DEPTH_DEF = 512;

  // Fixed field widths of a result.
  localparam int unsigned START_W   = 9;
  localparam int unsigned LENGTH_W  = 10;
  localparam int unsigned OUT_DATA_W = 24;
  localparam int unsigned IN_DATA_W  = 8;

  // Result slots in one bundle, and the bundle queue size.
  localparam int unsigned MAX_RESULTS = 4;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Byte codes.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_LBRC  = 8'h7B;
  localparam logic [7:0] CH_RBRC  = 8'h7D;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_SQUOT = 8'h27;
  localparam logic [7:0] CH_DQUOT = 8'h22;
  localparam logic [7:0] CH_BTICK = 8'h60;
  localparam logic [7:0] CH_BSLSH = 8'h5C;

  typedef struct packed {
    logic                endm;
    logic [LENGTH_W-1:0] len;
    logic [START_W-1:0]  start;
  } rec_t;

  // All results caused by one input byte; last_idx is the count minus one.
  typedef struct packed {
    logic [1:0]                   last_idx;
    rec_t [MAX_RESULTS-1:0]       recs;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_LF) || (c == CH_TAB);
  endfunction

  function automatic logic is_cand(input logic [7:0] c);
    return (c == CH_EQ) || (c == CH_BANG) || (c == CH_LT) || (c == CH_GT) ||
           (c == CH_AMP) || (c == CH_BAR);
  endfunction

  // Single-byte punctuation other than the pair candidates.
  function automatic logic is_punct(input logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH) ||
           (c == CH_PCT) || (c == CH_CARET) || (c == CH_TILDE) || (c == CH_LPAR) ||
           (c == CH_RPAR) || (c == CH_LBRC) || (c == CH_RBRC) || (c == CH_LBRK) ||
           (c == CH_RBRK) || (c == CH_SEMI) || (c == CH_COMMA) || (c == CH_COLON) ||
           (c == CH_DOT) || (c == CH_QUEST) || (c == CH_SQUOT) || (c == CH_DQUOT) ||
           (c == CH_BTICK) || (c == CH_BSLSH);
  endfunction

  function automatic logic pairs_with(input logic [7:0] first, input logic [7:0] second);
    logic r;
    r = 1'b0;
    if ((first == CH_AMP) || (first == CH_BAR)) begin
      r = (second == first);
    end else if (is_cand(first)) begin
      r = (second == CH_EQ);
    end
    return r;
  endfunction

endpackage

// ----- src/slt_front.sv -----
// Front end: classifies each byte, keeps the lexer state and builds one result bundle.
module slt_front #(
  parameter int unsigned SOURCE_DEPTH = slt_pkg::SOURCE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        ch,
  input  logic              end_of_text,
  output logic              push,
  output slt_pkg::bundle_t  bundle
);
  import slt_pkg::*;

  localparam int unsigned PW = $clog2(SOURCE_DEPTH + 1);
  localparam int unsigned SW = $clog2(SOURCE_DEPTH);
  localparam int unsigned XW = PW + LENGTH_W;
  localparam logic [PW-1:0] POS_MAX = PW'(SOURCE_DEPTH);
  localparam logic [SW-1:0] OFF_MAX = SW'(SOURCE_DEPTH - 1);

  logic [PW-1:0] pos_r, pos_nxt;
  logic [SW-1:0] ws_r, ws_nxt;
  logic          wo_r, wo_nxt;
  logic [7:0]    hb_r, hb_nxt;
  logic          hv_r, hv_nxt;

  logic          at_lim, consumed, sp, ca, pu, wb, wo1, hv1;
  logic [SW-1:0] off, prev, ws1;
  logic [PW-1:0] pos_inc;
  logic [PW-1:0] len_mid, len_fin;
  logic [XW-1:0] off_x, prev_x, ws_x, ws1_x, len_mid_x, len_fin_x;
  rec_t          ev [6];
  logic [5:0]    en;

  assign at_lim  = (pos_r >= POS_MAX);
  assign off     = at_lim ? OFF_MAX : pos_r[SW-1:0];
  assign prev    = (pos_r == '0) ? '0 : SW'(pos_r - PW'(1));
  assign pos_inc = at_lim ? pos_r : pos_r + PW'(1);

  assign consumed = hv_r && pairs_with(hb_r, ch);
  assign sp = is_space(ch);
  assign ca = is_cand(ch);
  assign pu = is_punct(ch);
  assign wb = !(sp || ca || pu);

  assign wo1 = consumed ? wo_r : wb;
  assign ws1 = (!consumed && wb && !wo_r) ? off : ws_r;
  assign hv1 = !consumed && ca;

  // A word length is the distance from its start, zero if the start lies ahead.
  assign len_mid = (pos_r >= PW'(ws_r)) ? pos_r - PW'(ws_r) : '0;
  assign len_fin = (pos_inc >= PW'(ws1)) ? pos_inc - PW'(ws1) : '0;

  assign off_x     = XW'(off);
  assign prev_x    = XW'(prev);
  assign ws_x      = XW'(ws_r);
  assign ws1_x     = XW'(ws1);
  assign len_mid_x = XW'(len_mid);
  assign len_fin_x = XW'(len_fin);

  always_comb begin
    ev[0] = '{endm: 1'b0, len: consumed ? 10'd2 : 10'd1, start: prev_x[START_W-1:0]};
    ev[1] = '{endm: 1'b0, len: len_mid_x[LENGTH_W-1:0], start: ws_x[START_W-1:0]};
    ev[2] = '{endm: 1'b0, len: 10'd1, start: off_x[START_W-1:0]};
    ev[3] = '{endm: 1'b0, len: 10'd1, start: off_x[START_W-1:0]};
    ev[4] = '{endm: 1'b0, len: len_fin_x[LENGTH_W-1:0], start: ws1_x[START_W-1:0]};
    ev[5] = '{endm: 1'b1, len: '0, start: '0};
    en[0] = hv_r;
    en[1] = !consumed && !wb && wo_r;
    en[2] = !consumed && pu;
    en[3] = end_of_text && hv1;
    en[4] = end_of_text && wo1;
    en[5] = end_of_text;
  end

  // Pack the enabled results in order into the bundle slots.
  always_comb begin
    logic [2:0] n;
    n = '0;
    bundle = '0;
    for (int i = 0; i < 6; i++) begin
      if (en[i]) begin
        bundle.recs[n[1:0]] = ev[i];
        n = n + 3'd1;
      end
    end
    bundle.last_idx = n[1:0] - 2'd1;
    push = accept && (n != 3'd0);
  end

  always_comb begin
    pos_nxt = pos_r;
    ws_nxt  = ws_r;
    wo_nxt  = wo_r;
    hb_nxt  = hb_r;
    hv_nxt  = hv_r;
    if (accept) begin
      if (end_of_text) begin
        pos_nxt = '0;
        ws_nxt  = '0;
        wo_nxt  = 1'b0;
        hb_nxt  = '0;
        hv_nxt  = 1'b0;
      end else begin
        pos_nxt = pos_inc;
        ws_nxt  = ws1;
        wo_nxt  = wo1;
        hb_nxt  = hv1 ? ch : hb_r;
        hv_nxt  = hv1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      ws_r  <= '0;
      wo_r  <= 1'b0;
      hb_r  <= '0;
      hv_r  <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      ws_r  <= ws_nxt;
      wo_r  <= wo_nxt;
      hb_r  <= hb_nxt;
      hv_r  <= hv_nxt;
    end
  end

endmodule

// ----- src/slt_queue.sv -----
// Bundle queue between front and back end, with a registered head entry.
module slt_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  slt_pkg::bundle_t  din,
  input  logic              pop,
  output slt_pkg::bundle_t  dout,
  output slt_pkg::q_stat_t  stat
);
  import slt_pkg::*;

  bundle_t             mem [QUEUE_DEPTH];
  bundle_t             head_r;
  logic                head_v_r, head_v_nxt;
  logic [QPTR_W-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                load, mem_rd, bypass, mem_wr;

  assign load   = !head_v_r || pop;
  assign mem_rd = load && (cnt_r != '0);
  assign bypass = load && (cnt_r == '0) && push;
  assign mem_wr = push && !bypass;

  always_comb begin
    wr_nxt     = mem_wr ? wr_r + QPTR_W'(1) : wr_r;
    rd_nxt     = mem_rd ? rd_r + QPTR_W'(1) : rd_r;
    cnt_nxt    = cnt_r + QCNT_W'(mem_wr) - QCNT_W'(mem_rd);
    head_v_nxt = load ? (mem_rd || bypass) : head_v_r;
  end

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      mem[wr_r] <= din;
    end
    if (mem_rd) begin
      head_r <= mem[rd_r];
    end else if (bypass) begin
      head_r <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r     <= '0;
      rd_r     <= '0;
      cnt_r    <= '0;
      head_v_r <= 1'b0;
    end else begin
      wr_r     <= wr_nxt;
      rd_r     <= rd_nxt;
      cnt_r    <= cnt_nxt;
      head_v_r <= head_v_nxt;
    end
  end

  assign dout       = head_r;
  assign stat.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.valid = head_v_r;

endmodule

// ----- src/slt_back.sv -----
// Back end: hands out the results of each bundle one per transaction.
module slt_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  slt_pkg::bundle_t                    qdata,
  input  slt_pkg::q_stat_t                    qstat,
  output logic                                pop,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [slt_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                out_tuser,
  output logic                                out_tlast
);
  import slt_pkg::*;

  bundle_t    b_r;
  logic [1:0] idx_r, idx_nxt;
  logic       busy_r, busy_nxt;
  logic       acc, at_end;
  rec_t       rec;

  assign acc    = busy_r && out_tready;
  assign at_end = (idx_r == b_r.last_idx);
  assign pop    = qstat.valid && (!busy_r || (acc && at_end));

  always_comb begin
    idx_nxt  = idx_r;
    busy_nxt = busy_r;
    if (pop) begin
      idx_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (acc) begin
      if (at_end) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b_r <= qdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      idx_r  <= idx_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign rec        = b_r.recs[idx_r];
  assign out_tvalid = busy_r;
  assign out_tdata  = {(OUT_DATA_W - START_W - LENGTH_W)'(0), rec.len, rec.start};
  assign out_tuser  = rec.endm;
  assign out_tlast  = at_end;

endmodule

// ----- src/script_lexer_tokenizer.sv -----
// Top level of the streaming script lexer tokenizer.
//
//   Channel   Direction  Payload
//   in_       slave      tdata[7:0] = ch, tlast = end_of_text
//   out_      master     tdata[8:0] = token_start, tdata[18:9] = token_length,
//                        tuser = end_marker, tlast = last result of its input byte
//
// The block accepts one source byte per cycle while its bundle queue has room.
// Each byte is classified in the front end in the cycle it is accepted, and all
// results it causes (up to three) enter the queue as one bundle; the back end then
// presents them one per cycle while out_tready is high. A result passes through the
// queue head register and the back-end bundle register before it appears on out_.
// The queue holds five bundles (four in memory plus a registered head), so the input
// keeps flowing while the output is stalled until those fill up.
// Reset is synchronous and active low; it clears all position and word state.
module script_lexer_tokenizer #(
  parameter int unsigned SOURCE_DEPTH = slt_pkg::SOURCE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [slt_pkg::IN_DATA_W-1:0]   in_tdata,   // [7:0] ch
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [slt_pkg::OUT_DATA_W-1:0]  out_tdata,  // [8:0] token_start, [18:9] token_length
  output logic                            out_tuser,  // [0] end_marker
  output logic                            out_tlast
);
  import slt_pkg::*;

  logic     in_acc;
  logic     q_push, q_pop;
  bundle_t  f_bundle, q_head;
  q_stat_t  q_stat;

  // A byte is taken whenever the queue can hold the bundle it might produce.
  assign in_tready = !q_stat.full;
  assign in_acc    = in_tvalid && in_tready;

  slt_front #(
    .SOURCE_DEPTH(SOURCE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_acc),
    .ch         (in_tdata),
    .end_of_text(in_tlast),
    .push       (q_push),
    .bundle     (f_bundle)
  );

  slt_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .din  (f_bundle),
    .pop  (q_pop),
    .dout (q_head),
    .stat (q_stat)
  );

  slt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .qdata     (q_head),
    .qstat     (q_stat),
    .pop       (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

`ifndef NO_ASSERTIONS
  // The end marker carries zero start and length and closes its byte's results.
  a_end_marker: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> ((out_tdata[18:0] == 19'd0) && out_tlast))
    else $error("end marker with nonzero fields or without tlast");

  // The back end only takes a bundle that the queue actually holds.
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_stat.valid)
    else $error("bundle taken from an empty queue");

  // A full memory implies a valid head entry.
  a_full_head: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> q_stat.valid)
    else $error("queue memory full while head is empty");
`endif

endmodule
